FILE: rtl/core/cr_pkg.sv
`default_nettype none

package cr_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int RATE_FRAC_BITS = 16;
   localparam int RATE_BITS      = 19;
   localparam int COUNT_BITS     = 32;
   localparam int CHAN_BITS      = 2;
   localparam int MAX_OUT        = 16;
   localparam int OUT_CNT_BITS   = $clog2(MAX_OUT + 1);
   localparam int ITEM_BITS      = 2 * SAMPLE_BITS;
   // horner accumulator and product widths
   localparam int H_BITS         = SAMPLE_BITS + 8;
   localparam int F_BITS         = RATE_FRAC_BITS + 1;
   localparam int P_BITS         = H_BITS + F_BITS;
   // phase (k * rate) and output count widths
   localparam int X_BITS         = COUNT_BITS + RATE_FRAC_BITS;
   localparam int ACC_BITS       = X_BITS + 6;
   localparam int K_BITS         = COUNT_BITS + 3;
   localparam int RBIT_BITS      = $clog2(RATE_BITS);

   localparam logic [RATE_BITS-1:0] RATE_MIN = RATE_BITS'(1 << (RATE_FRAC_BITS - 2));
   localparam logic [RATE_BITS-1:0] RATE_MAX = RATE_BITS'(4 << RATE_FRAC_BITS);

   typedef enum logic [1:0] {
      CSR_RATE     = 2'd0,
      CSR_FRAMES   = 2'd1,
      CSR_CHANNELS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] right;
      logic signed [SAMPLE_BITS-1:0] left;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CHECK,
      BK_READ,
      BK_LSTART,
      BK_LWAIT,
      BK_RSTART,
      BK_RWAIT,
      BK_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      IP_IDLE,
      IP_MUL,
      IP_ADD
   } interp_state_type;

   // interp unit request and response
   typedef struct packed {
      logic                          start;
      logic signed [SAMPLE_BITS-1:0] s0;
      logic signed [SAMPLE_BITS-1:0] s1;
      logic signed [SAMPLE_BITS-1:0] s2;
      logic signed [SAMPLE_BITS-1:0] s3;
      logic [RATE_FRAC_BITS-1:0]     frac;
   } interp_req_type;

   typedef struct packed {
      logic                          done;
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          clip;
   } interp_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/cubic_resampler.sv
`default_nettype none

// cubic_resampler: varispeed stereo resampler with catmull-rom interpolation
//
// req channel: one source frame per item (left and right signed 24-bit samples)
// rsp channel: interpolated output frames; tlast marks the final frame of the
//    clip, tuser flags a frame in which either sample saturated
// csr port: write-only; rate (Q3.16, clamped 0.25..4), frame count, channels
//    (1 = mono on the left lane, right output forced to zero)
// an input item is stored into a four-slot history, then every output frame
// whose neighbors have arrived is produced, at most sixteen per item
// sequence: per output frame, the check step, the history reads, then one pass
// of the shared three-step horner unit per lane, then the output load; an item
// that yields no output passes only the check step. a two-entry input queue
// lets the next item be taken early
// a rate write starts a rebuild of the output position, during which no item
// is taken
// reset: rate 1.0, one frame, stereo, empty history, no clip in progress
// rsp stall: the output register holds its item; the back end waits, the input
// queue fills and then req_tready drops
// once the last frame is out further items are taken and dropped until reset
module cubic_resampler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // left_sample, right_sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // out_left, out_right
   output logic             rsp_tlast,   // last_output
   output logic             rsp_tuser,   // clipped
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);
   import cr_pkg::*;

   logic     item_valid;
   logic     item_pop;
   item_type item;

   // front: accept and queue source frames
   cr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // back: history, phase tracking, interpolation and output register
   cr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: rtl/core/cr_front.sv
`default_nettype none

module cr_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [cr_pkg::ITEM_BITS-1:0] req_tdata,
   output logic                              item_valid,
   output cr_pkg::item_type                  item,
   input  wire logic                         item_pop
);
   import cr_pkg::*;

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_type'(req_tdata);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/cr_interp.sv
`default_nettype none

module cr_interp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cr_pkg::interp_req_type req,
   output cr_pkg::interp_rsp_type     rsp
);
   import cr_pkg::*;

   localparam logic signed [H_BITS-1:0] SMAX = H_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [H_BITS-1:0] SMIN = -SMAX - H_BITS'(1);
   localparam logic signed [P_BITS-1:0] HALF = P_BITS'(1 << (RATE_FRAC_BITS - 1));

   interp_state_type          state_ff, state_in;
   logic [1:0]                round_ff, round_in;
   logic signed [H_BITS-1:0]  a_ff, b_ff, s1x2_ff, h_ff;
   logic signed [P_BITS-1:0]  p_ff;
   logic signed [F_BITS-1:0]  f_ff;
   logic signed [H_BITS-1:0]  x0, x1, x2, x3;
   logic signed [H_BITS-1:0]  coef_a, coef_b, coef_c;
   logic signed [H_BITS-1:0]  addend, h_next, y_full;
   logic signed [P_BITS-1:0]  p_round;
   logic                      done_ff, clip_ff;
   logic signed [SAMPLE_BITS-1:0] value_ff;

   always_comb begin
      x0     = H_BITS'(req.s0);
      x1     = H_BITS'(req.s1);
      x2     = H_BITS'(req.s2);
      x3     = H_BITS'(req.s3);
      coef_a = x2 - x0;
      coef_b = (x0 <<< 1) - (x1 <<< 2) - x1 + (x2 <<< 2) - x3;
      coef_c = x3 - x0 + (x1 <<< 1) + x1 - (x2 <<< 1) - x2;
      case (round_ff)
         2'd0:    addend = b_ff;
         2'd1:    addend = a_ff;
         default: addend = s1x2_ff;
      endcase
      p_round = (p_ff + HALF) >>> RATE_FRAC_BITS;
      h_next  = addend + p_round[H_BITS-1:0];
      y_full  = (h_next + H_BITS'(1)) >>> 1;
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      unique case (state_ff)
         IP_IDLE: begin
            if (req.start) begin
               state_in = IP_MUL;
               round_in = 2'd0;
            end
         end
         IP_MUL: state_in = IP_ADD;
         IP_ADD: begin
            if (round_ff == 2'd2) begin
               state_in = IP_IDLE;
            end else begin
               state_in = IP_MUL;
               round_in = round_ff + 2'd1;
            end
         end
         default: state_in = IP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IP_IDLE;
         round_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         done_ff  <= (state_ff == IP_ADD) && (round_ff == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == IP_IDLE && req.start) begin
         a_ff    <= coef_a;
         b_ff    <= coef_b;
         h_ff    <= coef_c;
         s1x2_ff <= x1 <<< 1;
         f_ff    <= {1'b0, req.frac};
      end
      if (state_ff == IP_MUL) begin
         p_ff <= h_ff * f_ff;
      end
      if (state_ff == IP_ADD) begin
         h_ff <= h_next;
         if (round_ff == 2'd2) begin
            // saturate to the sample range
            if (y_full > SMAX) begin
               value_ff <= SMAX[SAMPLE_BITS-1:0];
               clip_ff  <= 1'b1;
            end else if (y_full < SMIN) begin
               value_ff <= SMIN[SAMPLE_BITS-1:0];
               clip_ff  <= 1'b1;
            end else begin
               value_ff <= y_full[SAMPLE_BITS-1:0];
               clip_ff  <= 1'b0;
            end
         end
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;
   assign rsp.clip  = clip_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cr_back.sv
`default_nettype none

module cr_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_addr,
   input  wire logic [cr_pkg::COUNT_BITS-1:0] csr_wdata,
   input  wire logic                          item_valid,
   input  wire cr_pkg::item_type              item,
   output logic                               item_pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [cr_pkg::ITEM_BITS-1:0]       rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser
);
   import cr_pkg::*;

   // configuration
   logic [RATE_BITS-1:0]  rate_ff;
   logic [COUNT_BITS-1:0] frames_ff;
   logic [CHAN_BITS-1:0]  chans_ff;
   logic [RATE_BITS-1:0]  eff_rate;
   logic                  stereo;

   // clip state
   item_type              hist_mem [4];
   item_type              rdata_ff;
   item_type              s_ff [4];
   logic [COUNT_BITS-1:0] recv_ff;
   logic [COUNT_BITS-1:0] r_ff;
   logic [ACC_BITS-1:0]   acc_ff;
   logic [ACC_BITS-1:0]   kr_ff;
   logic [K_BITS-1:0]     k_ff;
   logic                  clip_done_ff;

   // k * rate rebuild after a rate write
   logic                  mul_busy_ff;
   logic [RBIT_BITS-1:0]  mul_bit_ff;

   back_state_type        state_ff, state_in;
   logic [OUT_CNT_BITS-1:0] out_cnt_ff;
   logic [2:0]            rd_cnt_ff;
   logic [1:0]            slot_ff [4];
   logic [RATE_FRAC_BITS-1:0] frac_ff;
   logic                  last_ff;
   logic                  clip_acc_ff;
   logic signed [SAMPLE_BITS-1:0] yl_ff;
   logic signed [SAMPLE_BITS-1:0] yr_ff;

   logic                  rsp_valid_ff;
   item_type              rsp_data_ff;
   logic                  rsp_last_ff, rsp_clip_ff;

   // check-step signals
   logic [COUNT_BITS-1:0] nm1;
   logic [X_BITS-1:0]     lim, x_limit, phase;
   logic [COUNT_BITS-1:0] frame;
   logic [COUNT_BITS:0]   p1, need;
   logic                  emit_ok, last_now, go;
   logic                  accept, drop, out_load;
   logic [1:0]            cap_idx;
   logic                  ch_right;
   interp_req_type        ireq;
   interp_rsp_type        irsp;

   always_comb begin
      eff_rate = rate_ff;
      if (rate_ff < RATE_MIN) eff_rate = RATE_MIN;
      if (rate_ff > RATE_MAX) eff_rate = RATE_MAX;
      stereo  = (chans_ff != CHAN_BITS'(1));
      nm1     = frames_ff - COUNT_BITS'(1);
      lim     = {nm1, {RATE_FRAC_BITS{1'b0}}};
      x_limit = {frames_ff, {RATE_FRAC_BITS{1'b0}}};
      phase   = (acc_ff < ACC_BITS'(lim)) ? acc_ff[X_BITS-1:0] : lim;
      frame   = phase[X_BITS-1:RATE_FRAC_BITS];
      p1      = {1'b0, frame} + (COUNT_BITS+1)'(1);
      need    = {1'b0, frame} + (COUNT_BITS+1)'(2);
      if (p1 > {1'b0, nm1}) p1 = {1'b0, nm1};
      if (need > {1'b0, nm1}) need = {1'b0, nm1};
      emit_ok  = (k_ff == '0) || (kr_ff + ACC_BITS'(eff_rate) <= ACC_BITS'(x_limit));
      last_now = (kr_ff + ACC_BITS'({eff_rate, 1'b0}) > ACC_BITS'(x_limit));
      go       = (out_cnt_ff < OUT_CNT_BITS'(MAX_OUT)) && emit_ok && (need <= {1'b0, r_ff});
      accept   = (state_ff == BK_IDLE) && item_valid && !mul_busy_ff;
      drop     = clip_done_ff || (frames_ff == '0);
      out_load = (state_ff == BK_OUT) && (!rsp_valid_ff || rsp_tready);
      cap_idx  = 2'(rd_cnt_ff - 3'd1);
      ch_right = (state_ff == BK_RSTART);
   end

   assign item_pop = accept;

   always_comb begin
      ireq.start = (state_ff == BK_LSTART) || (state_ff == BK_RSTART);
      ireq.s0    = ch_right ? s_ff[0].right : s_ff[0].left;
      ireq.s1    = ch_right ? s_ff[1].right : s_ff[1].left;
      ireq.s2    = ch_right ? s_ff[2].right : s_ff[2].left;
      ireq.s3    = ch_right ? s_ff[3].right : s_ff[3].left;
      ireq.frac  = frac_ff;
   end

   cr_interp u_interp (
      .clock (clock),
      .reset (reset),
      .req   (ireq),
      .rsp   (irsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (accept && !drop) state_in = BK_CHECK;
         BK_CHECK:  state_in = go ? BK_READ : BK_IDLE;
         BK_READ:   if (rd_cnt_ff == 3'd4) state_in = BK_LSTART;
         BK_LSTART: state_in = BK_LWAIT;
         BK_LWAIT:  if (irsp.done) state_in = stereo ? BK_RSTART : BK_OUT;
         BK_RSTART: state_in = BK_RWAIT;
         BK_RWAIT:  if (irsp.done) state_in = BK_OUT;
         BK_OUT: begin
            if (out_load) state_in = last_ff ? BK_IDLE : BK_CHECK;
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rate_ff      <= RATE_BITS'(1 << RATE_FRAC_BITS);
         frames_ff    <= COUNT_BITS'(1);
         chans_ff     <= CHAN_BITS'(2);
         recv_ff      <= '0;
         acc_ff       <= '0;
         kr_ff        <= '0;
         k_ff         <= '0;
         clip_done_ff <= 1'b0;
         mul_busy_ff  <= 1'b0;
         mul_bit_ff   <= '0;
         out_cnt_ff   <= '0;
         rd_cnt_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_RATE: begin
                  rate_ff     <= csr_wdata[RATE_BITS-1:0];
                  mul_busy_ff <= 1'b1;
                  mul_bit_ff  <= '0;
                  kr_ff       <= '0;
               end
               CSR_FRAMES:   frames_ff <= csr_wdata;
               CSR_CHANNELS: chans_ff  <= csr_wdata[CHAN_BITS-1:0];
               default: ;
            endcase
         end
         // shift-add k * rate, one rate bit a cycle while no csr write is made
         if (mul_busy_ff && !csr_we) begin
            if (eff_rate[mul_bit_ff]) begin
               kr_ff <= kr_ff + (ACC_BITS'(k_ff) << mul_bit_ff);
            end
            if (mul_bit_ff == RBIT_BITS'(RATE_BITS - 1)) begin
               mul_busy_ff <= 1'b0;
            end else begin
               mul_bit_ff <= mul_bit_ff + RBIT_BITS'(1);
            end
         end
         if (accept && !drop) begin
            out_cnt_ff <= '0;
            if (recv_ff < frames_ff) begin
               recv_ff <= recv_ff + COUNT_BITS'(1);
            end
         end
         if (state_ff == BK_CHECK) begin
            rd_cnt_ff <= 3'd0;
         end else if (state_ff == BK_READ) begin
            rd_cnt_ff <= rd_cnt_ff + 3'd1;
         end
         if (out_load) begin
            acc_ff     <= acc_ff + ACC_BITS'(eff_rate);
            kr_ff      <= kr_ff + ACC_BITS'(eff_rate);
            k_ff       <= k_ff + K_BITS'(1);
            out_cnt_ff <= out_cnt_ff + OUT_CNT_BITS'(1);
            if (last_ff) clip_done_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // history store, one frame of both lanes per slot
   always_ff @(posedge clock) begin
      if (accept && !drop && (recv_ff < frames_ff)) begin
         hist_mem[recv_ff[1:0]] <= '{right: stereo ? item.right : '0, left: item.left};
      end
      rdata_ff <= hist_mem[slot_ff[rd_cnt_ff[1:0]]];
   end

   always_ff @(posedge clock) begin
      if (accept && !drop) begin
         r_ff <= (recv_ff < frames_ff) ? recv_ff : nm1;
      end
      if (state_ff == BK_CHECK) begin
         frac_ff    <= phase[RATE_FRAC_BITS-1:0];
         last_ff    <= last_now;
         slot_ff[0] <= (frame == '0) ? 2'd0 : 2'(frame - COUNT_BITS'(1));
         slot_ff[1] <= frame[1:0];
         slot_ff[2] <= p1[1:0];
         slot_ff[3] <= need[1:0];
      end
      if (state_ff == BK_READ && rd_cnt_ff != 3'd0) begin
         s_ff[cap_idx] <= rdata_ff;
      end
      // lane results wait here so a stalled output item stays intact
      if (state_ff == BK_LWAIT && irsp.done) begin
         yl_ff       <= irsp.value;
         yr_ff       <= '0;
         clip_acc_ff <= irsp.clip;
      end
      if (state_ff == BK_RWAIT && irsp.done) begin
         yr_ff       <= irsp.value;
         clip_acc_ff <= clip_acc_ff | irsp.clip;
      end
      if (out_load) begin
         rsp_data_ff <= '{right: yr_ff, left: yl_ff};
         rsp_last_ff <= last_ff;
         rsp_clip_ff <= clip_acc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_clip_ff;

   a_no_out_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_OUT) |-> !clip_done_ff)
      else $error("output pending after clip finished");

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OUT_CNT_BITS'(MAX_OUT))
      else $error("more than sixteen results for one item");

   a_last_ends_clip: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |=> clip_done_ff)
      else $error("last output did not finish the clip");

endmodule

`default_nettype wire
